[hdl/tsfq_pkg.sv]
// Shared types and codes for the two-stack FIFO queue.
// No dependencies; imported by tsfq_ctrl, tsfq_dpath and the top level.
`default_nettype none
package tsfq_pkg;

    localparam int ACTION_BITS = 2;
    localparam int STATUS_BITS = 2;
    localparam int VALUE_BITS  = 32;

    typedef logic [ACTION_BITS-1:0] t_action;
    typedef logic [STATUS_BITS-1:0] t_status;

    localparam t_action ACT_ENQUEUE = 2'd0;
    localparam t_action ACT_DEQUEUE = 2'd1;
    localparam t_action ACT_PEEK    = 2'd2;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_OVERFLOW  = 2'd1;
    localparam t_status ST_UNDERFLOW = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic    in_push;      // write request word at inbox top
        logic    in_peek_rd;   // read inbox bottom
        logic    xfer_rd;      // read inbox top and pop it
        logic    out_rd;       // read outbox top
        logic    out_pop;      // with out_rd: pop the outbox
        logic    res_load;     // result ready for the output register
        logic    res_from_ram; // result value from a RAM read, else zero
        logic    res_from_in;  // RAM read came from the inbox
        t_status res_status;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_empty;
        logic out_empty;
        logic full;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

[hdl/tsfq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tsfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[hdl/tsfq_dpath.sv]
// Datapath: inbox and outbox stacks, their counts and the result register.
// Depends on tsfq_pkg and tsfq_ram.
`default_nettype none
module tsfq_dpath #(
    parameter int DEPTH     = 8,
    parameter int WORD_BITS = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire tsfq_pkg::t_cmd         i_cmd,
    input  wire logic [31:0]            i_word,
    input  wire logic                   i_res_ready,
    output tsfq_pkg::t_stat             o_stat,
    output logic                        o_res_valid,
    output logic [31:0]                 o_res_value,
    output tsfq_pkg::t_status           o_res_status
);
    import tsfq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CW-1:0] r_in_cnt, n_in_cnt;
    logic [CW-1:0] r_out_cnt, n_out_cnt;
    logic          r_mv, n_mv;
    logic [CW-1:0] in_top, out_top;
    logic [CW:0]   total;

    logic [WORD_BITS-1:0] word_st;
    logic [WORD_BITS-1:0] in_rdata, out_rdata, sel_rdata;
    logic [31:0]          rd_value;
    logic [AW-1:0]        in_raddr;

    logic                 r_valid;
    logic [31:0]          r_value;
    t_status              r_status;
    logic                 out_free;

    // input word is signed 32 bits; stored as WORD_BITS
    generate
        if (WORD_BITS <= 32) begin : g_in_narrow
            assign word_st = i_word[WORD_BITS-1:0];
        end else begin : g_in_wide
            assign word_st = {{(WORD_BITS-32){i_word[31]}}, i_word};
        end
        if (WORD_BITS >= 32) begin : g_out_wide
            assign rd_value = sel_rdata[31:0];
        end else begin : g_out_narrow
            assign rd_value = {{(32-WORD_BITS){1'b0}}, sel_rdata};
        end
    endgenerate

    assign in_top  = CW'(r_in_cnt - CW'(1));
    assign out_top = CW'(r_out_cnt - CW'(1));
    assign total   = {1'b0, r_in_cnt} + {1'b0, r_out_cnt};
    assign in_raddr = i_cmd.xfer_rd ? in_top[AW-1:0] : '0;

    tsfq_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH), .AW(AW)) u_inbox (
        .i_clk   (i_clk),
        .i_we    (i_cmd.in_push),
        .i_waddr (r_in_cnt[AW-1:0]),
        .i_wdata (word_st),
        .i_re    (i_cmd.xfer_rd | i_cmd.in_peek_rd),
        .i_raddr (in_raddr),
        .o_rdata (in_rdata)
    );

    // a move writes the inbox word read in the previous cycle
    tsfq_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH), .AW(AW)) u_outbox (
        .i_clk   (i_clk),
        .i_we    (r_mv),
        .i_waddr (r_out_cnt[AW-1:0]),
        .i_wdata (in_rdata),
        .i_re    (i_cmd.out_rd),
        .i_raddr (out_top[AW-1:0]),
        .o_rdata (out_rdata)
    );

    always_comb begin
        n_in_cnt  = r_in_cnt;
        n_out_cnt = r_out_cnt;
        n_mv      = i_cmd.xfer_rd;
        if (i_cmd.in_push) begin
            n_in_cnt = CW'(r_in_cnt + CW'(1));
        end else if (i_cmd.xfer_rd) begin
            n_in_cnt = in_top;
        end
        if (r_mv) begin
            n_out_cnt = CW'(r_out_cnt + CW'(1));
        end else if (i_cmd.out_rd && i_cmd.out_pop) begin
            n_out_cnt = out_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cnt  <= '0;
            r_out_cnt <= '0;
            r_mv      <= 1'b0;
        end else begin
            r_in_cnt  <= n_in_cnt;
            r_out_cnt <= n_out_cnt;
            r_mv      <= n_mv;
        end
    end

    assign sel_rdata = i_cmd.res_from_in ? in_rdata : out_rdata;
    assign out_free  = !r_valid || i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.res_load && out_free) begin
            r_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load && out_free) begin
            r_value  <= i_cmd.res_from_ram ? rd_value : '0;
            r_status <= i_cmd.res_status;
        end
    end

    assign o_stat.in_empty  = (r_in_cnt == '0);
    assign o_stat.out_empty = (r_out_cnt == '0);
    assign o_stat.full      = (total >= (CW+1)'(DEPTH));
    assign o_stat.out_free  = out_free;

    assign o_res_valid  = r_valid;
    assign o_res_value  = r_value;
    assign o_res_status = r_status;

endmodule
`default_nettype wire

[hdl/tsfq_ctrl.sv]
// Controller: decodes each request and sequences stack reads, transfers
// and result loading. Depends on tsfq_pkg.
`default_nettype none
module tsfq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    input  wire tsfq_pkg::t_action i_action,
    input  wire tsfq_pkg::t_stat   i_stat,
    output logic                   o_req_ready,
    output tsfq_pkg::t_cmd         o_cmd
);
    import tsfq_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RES  = 3'd1; // result without RAM data
    localparam logic [2:0] S_RDW  = 3'd2; // RAM read data now valid
    localparam logic [2:0] S_XFER = 3'd3; // move inbox onto outbox
    localparam logic [2:0] S_POP  = 3'd4; // pop outbox after a transfer

    logic [2:0] r_state, n_state;
    t_status    r_status, n_status;
    logic       r_from_in, n_from_in;
    logic       accept;

    // no request is taken while reset is held
    assign o_req_ready = (r_state == S_IDLE) && i_rst_n;
    assign accept      = i_req_valid && o_req_ready;

    always_comb begin
        n_state   = r_state;
        n_status  = r_status;
        n_from_in = r_from_in;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status  = ST_OK;
                    n_from_in = 1'b0;
                    n_state   = S_RES;
                    case (i_action)
                        ACT_ENQUEUE: begin
                            if (i_stat.full) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                o_cmd.in_push = 1'b1;
                            end
                        end
                        ACT_DEQUEUE: begin
                            if (!i_stat.out_empty) begin
                                o_cmd.out_rd  = 1'b1;
                                o_cmd.out_pop = 1'b1;
                                n_state       = S_RDW;
                            end else if (!i_stat.in_empty) begin
                                n_state = S_XFER;
                            end else begin
                                n_status = ST_UNDERFLOW;
                            end
                        end
                        ACT_PEEK: begin
                            if (!i_stat.out_empty) begin
                                o_cmd.out_rd = 1'b1;
                                n_state      = S_RDW;
                            end else if (!i_stat.in_empty) begin
                                o_cmd.in_peek_rd = 1'b1;
                                n_from_in        = 1'b1;
                                n_state          = S_RDW;
                            end else begin
                                n_status = ST_UNDERFLOW;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_RES: begin
                o_cmd.res_load   = 1'b1;
                o_cmd.res_status = r_status;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_RDW: begin
                o_cmd.res_load     = 1'b1;
                o_cmd.res_from_ram = 1'b1;
                o_cmd.res_from_in  = r_from_in;
                o_cmd.res_status   = r_status;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_XFER: begin
                // one inbox read per cycle; each outbox write lands in the next cycle
                if (!i_stat.in_empty) begin
                    o_cmd.xfer_rd = 1'b1;
                end else begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                o_cmd.out_rd  = 1'b1;
                o_cmd.out_pop = 1'b1;
                n_state       = S_RDW;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_from_in <= n_from_in;
    end

endmodule
`default_nettype wire

[hdl/two_stack_fifo_queue.sv]
// Top level of the two-stack FIFO queue: controller plus datapath.
// Depends on tsfq_pkg, tsfq_ctrl, tsfq_dpath (and tsfq_ram below it).
//
// channel   dir  tdata               tuser
// s_axis    in   [31:0] data_word    [1:0] action
// m_axis    out  [31:0] value        [1:0] status
//
// Enqueue, peek and dequeue from a non-empty outbox go from the accept
// cycle to a state that loads the result register; a dequeue that finds
// the outbox empty first moves every inbox word onto the outbox through the
// one-word-per-cycle inbox read port, then pops the outbox. Reset is
// synchronous, active low, and empties both stacks. A full result register
// stalls the block in its last state until m_axis_tready frees it.
`default_nettype none
module two_stack_fifo_queue #(
    parameter int DEPTH     = 8,
    parameter int WORD_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // [31:0] data_word
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] action
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,  // [31:0] value
    output logic      [1:0]  m_axis_tuser   // [1:0] status
);
    import tsfq_pkg::*;

    t_cmd    cmd;
    t_stat   stat;
    t_status res_status;

    tsfq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_action    (s_axis_tuser),
        .i_stat      (stat),
        .o_req_ready (s_axis_tready),
        .o_cmd       (cmd)
    );

    tsfq_dpath #(.DEPTH(DEPTH), .WORD_BITS(WORD_BITS)) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_word       (s_axis_tdata),
        .i_res_ready  (m_axis_tready),
        .o_stat       (stat),
        .o_res_valid  (m_axis_tvalid),
        .o_res_value  (m_axis_tdata),
        .o_res_status (res_status)
    );

    assign m_axis_tuser = res_status;

endmodule
`default_nettype wire
